FILE: hdl/tga_pkg.sv
// Shared types and constants for the TGA true-color stream parser.
// Depends on nothing; used by the channel interfaces and the top level.
package tga_pkg;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_COLOR_MAP  = 3'd1;
  localparam logic [2:0] ERR_IMAGE_TYPE = 3'd2;
  localparam logic [2:0] ERR_INTERLEAVE = 3'd3;
  localparam logic [2:0] ERR_DEPTH      = 3'd4;

  localparam logic [7:0] IMAGE_TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] INTERLEAVE_MASK      = 8'd192;
  localparam logic [7:0] ALPHA_BITS_MASK      = 8'd15;
  localparam logic [7:0] DEPTH_24             = 8'd24;
  localparam logic [7:0] DEPTH_32             = 8'd32;
  localparam logic [7:0] ALPHA_BITS_8         = 8'd8;

  localparam logic [4:0] HDR_ID_LEN     = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_DEPTH      = 5'd16;
  localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

FILE: hdl/tga_if.sv
// Valid/ready channel interfaces for file bytes and parser results.
// Depends on tga_pkg.
interface tga_byte_if;
  import tga_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tga_result_if;
  import tga_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/tga_truecolor_stream_parser.sv
// Top level of the TGA uncompressed true-color stream parser.
// Depends on tga_pkg and the channel interfaces in tga_if.sv.
//
// Channel    Dir  Payload                       Transactions
// byte_i     in   data_byte, frame_start        one file byte each
// result_o   out  header / error / pixel item   zero or one per byte
//
// One byte per cycle while the output register can take a result; each byte
// updates the parser state registers and any result lands in one output register.
// A byte is taken whenever the output register is empty or is being drained.
// Reset puts the parser in the header phase with the output register empty.
// A stalled result blocks input only until it is taken.
module tga_truecolor_stream_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  tga_byte_if.sink         byte_i,
  tga_result_if.source     result_o
);
  import tga_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PIXELS,
    PH_IDLE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  id_rem_q, id_rem_d;
  logic [7:0]  low_hold_q, low_hold_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  depth_q, depth_d;
  logic        alpha_q, alpha_d;
  logic        flip_q, flip_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [1:0]  bip_q, bip_d;
  logic [23:0] partial_q, partial_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  phase_e      ph_e;
  logic [4:0]  hdr_idx_e;
  logic [7:0]  id_rem_e, low_hold_e, depth_e;
  logic [15:0] width_e, height_e, col_e, row_e;
  logic        alpha_e, flip_e;
  logic [1:0]  bip_e;
  logic [23:0] partial_e;

  logic        accept;
  logic        res_valid;
  result_t     res;
  logic [7:0]  b;
  logic [1:0]  final_byte;
  logic [16:0] col_inc, row_inc;
  logic [7:0]  id_dec;

  assign byte_i.ready   = !out_valid_q || result_o.ready;
  assign accept         = byte_i.valid && byte_i.ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;
  assign b              = byte_i.data.data_byte;

  // restart view of the state
  always_comb begin
    if (byte_i.data.frame_start) begin
      ph_e = PH_HEADER;  hdr_idx_e = '0; id_rem_e = '0;  low_hold_e = '0;
      width_e = '0;      height_e = '0;  depth_e = '0;   alpha_e = 1'b0;
      flip_e = 1'b0;     col_e = '0;     row_e = '0;     bip_e = '0;
      partial_e = '0;
    end else begin
      ph_e = phase_q;    hdr_idx_e = hdr_idx_q; id_rem_e = id_rem_q;
      low_hold_e = low_hold_q; width_e = width_q; height_e = height_q;
      depth_e = depth_q; alpha_e = alpha_q; flip_e = flip_q; col_e = col_q;
      row_e = row_q;     bip_e = bip_q;  partial_e = partial_q;
    end
  end

  assign final_byte = alpha_e ? 2'd3 : 2'd2;
  assign col_inc    = {1'b0, col_e} + 17'd1;
  assign row_inc    = {1'b0, row_e} + 17'd1;
  assign id_dec     = id_rem_e - 8'd1;

  always_comb begin
    phase_d = ph_e;      hdr_idx_d = hdr_idx_e; id_rem_d = id_rem_e;
    low_hold_d = low_hold_e; width_d = width_e; height_d = height_e;
    depth_d = depth_e;   alpha_d = alpha_e; flip_d = flip_e; col_d = col_e;
    row_d = row_e;       bip_d = bip_e;     partial_d = partial_e;
    res = '0;
    res_valid = 1'b0;

    case (ph_e)
      PH_HEADER: begin
        if (hdr_idx_e < HDR_DESCRIPTOR) begin
          hdr_idx_d = hdr_idx_e + 5'd1;
        end
        case (hdr_idx_e)
          HDR_ID_LEN: id_rem_d = b;
          HDR_CMAP_TYPE: begin
            if (b != 8'd0) begin
              res.kind = KIND_ERROR; res.error_code = ERR_COLOR_MAP;
              res_valid = 1'b1;      phase_d = PH_IDLE;
              hdr_idx_d = hdr_idx_e;
            end
          end
          HDR_IMG_TYPE: begin
            if (b != IMAGE_TYPE_TRUECOLOR) begin
              res.kind = KIND_ERROR; res.error_code = ERR_IMAGE_TYPE;
              res_valid = 1'b1;      phase_d = PH_IDLE;
              hdr_idx_d = hdr_idx_e;
            end
          end
          HDR_WIDTH_LO, HDR_HEIGHT_LO: low_hold_d = b;
          HDR_WIDTH_HI: width_d = {b, low_hold_e};
          HDR_HEIGHT_HI: height_d = {b, low_hold_e};
          HDR_DEPTH: depth_d = b;
          HDR_DESCRIPTOR: begin
            res_valid = 1'b1;
            if ((b & INTERLEAVE_MASK) != 8'd0) begin
              res.kind = KIND_ERROR; res.error_code = ERR_INTERLEAVE;
              phase_d = PH_IDLE;
            end else if (!((depth_e == DEPTH_24 && (b & ALPHA_BITS_MASK) == 8'd0) ||
                           (depth_e == DEPTH_32 &&
                            (b & ALPHA_BITS_MASK) == ALPHA_BITS_8))) begin
              flip_d = b[5];
              res.kind = KIND_ERROR; res.error_code = ERR_DEPTH;
              phase_d = PH_IDLE;
            end else begin
              flip_d = b[5];
              alpha_d = (depth_e == DEPTH_32);
              res.kind = KIND_HEADER;
              res.has_alpha = (depth_e == DEPTH_32);
              res.image_width = width_e;
              res.image_height = height_e;
              col_d = '0; row_d = '0; bip_d = '0; partial_d = '0;
              if (id_rem_e != 8'd0) begin
                phase_d = PH_IDSKIP;
              end else if (width_e == 16'd0 || height_e == 16'd0) begin
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_PIXELS;
              end
            end
          end
          default: ;
        endcase
      end
      PH_IDSKIP: begin
        id_rem_d = id_dec;
        if (id_dec == 8'd0) begin
          phase_d = (width_e == 16'd0 || height_e == 16'd0) ? PH_IDLE : PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (bip_e < final_byte) begin
          case (bip_e)
            2'd0: partial_d[7:0] = partial_e[7:0] | b;
            2'd1: partial_d[15:8] = partial_e[15:8] | b;
            2'd2: partial_d[23:16] = partial_e[23:16] | b;
            default: ;
          endcase
          bip_d = bip_e + 2'd1;
        end else begin
          res_valid = 1'b1;
          res.kind = KIND_PIXEL;
          res.red = alpha_e ? partial_e[23:16] : b;
          res.alpha = alpha_e ? b : 8'd0;
          res.green = partial_e[15:8];
          res.blue = partial_e[7:0];
          res.pixel_x = col_e;
          res.pixel_y = flip_e ? (height_e - 16'd1 - row_e) : row_e;
          res.has_alpha = alpha_e;
          bip_d = '0;
          partial_d = '0;
          if (col_inc >= {1'b0, width_e}) begin
            col_d = '0;
            if (row_inc >= {1'b0, height_e}) begin
              res.last = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              row_d = row_inc[15:0];
            end
          end else begin
            col_d = col_inc[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d = out_q;
    if (accept) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hdr_idx_q <= '0; id_rem_q <= '0; low_hold_q <= '0;
      width_q <= '0;        height_q <= '0;  depth_q <= '0;  alpha_q <= 1'b0;
      flip_q <= 1'b0;       col_q <= '0;     row_q <= '0;    bip_q <= '0;
      partial_q <= '0;      out_valid_q <= 1'b0;  out_q <= '0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;   hdr_idx_q <= hdr_idx_d; id_rem_q <= id_rem_d;
        low_hold_q <= low_hold_d; width_q <= width_d; height_q <= height_d;
        depth_q <= depth_d;   alpha_q <= alpha_d; flip_q <= flip_d;
        col_q <= col_d;       row_q <= row_d;     bip_q <= bip_d;
        partial_q <= partial_d;
      end
      out_valid_q <= out_valid_d;
      out_q <= out_d;
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for tga_truecolor_stream_parser: drives TGA byte streams and
// checks every header, error and pixel transaction against a built-in predictor.
// Depends on tga_pkg and the channel interfaces in tga_if.sv.
module tb;
  import tga_pkg::*;

  localparam int TOTAL_BYTES    = 1850;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT    = 50;

  typedef enum logic [2:0] {PH_HEADER, PH_ID_SKIP, PH_PIXELS, PH_IDLE} parse_phase_e;

  class tga_scoreboard;
    result_t      expected_q[$];
    int           errors;
    parse_phase_e phase;
    logic [4:0]   hdr_idx;
    logic [7:0]   id_left;
    logic [7:0]   lo_hold;
    logic [7:0]   depth_b;
    logic [15:0]  width_r;
    logic [15:0]  height_r;
    logic [15:0]  col;
    logic [15:0]  row;
    logic         alpha_m;
    logic         flip;
    logic [1:0]   byte_idx;
    logic [23:0]  partial;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_HEADER;
      hdr_idx  = '0;
      id_left  = '0;
      lo_hold  = '0;
      depth_b  = '0;
      width_r  = '0;
      height_r = '0;
      col      = '0;
      row      = '0;
      alpha_m  = 1'b0;
      flip     = 1'b0;
      byte_idx = '0;
      partial  = '0;
    endfunction

    function bit idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function parse_phase_e after_id();
      return (width_r == 0 || height_r == 0) ? PH_IDLE : PH_PIXELS;
    endfunction

    // Advances the parser by one accepted byte and queues any result it causes.
    function void note_byte(byte_t b);
      result_t    r;
      bit         got;
      logic [7:0] d;
      logic [1:0] final_idx;
      r   = '0;
      got = 1'b0;
      d   = b.data_byte;
      if (b.frame_start) restart();
      case (phase)
        PH_HEADER: begin
          case (hdr_idx)
            HDR_ID_LEN: id_left = d;
            HDR_CMAP_TYPE: if (d != 8'd0) begin
              r.kind = KIND_ERROR;
              r.error_code = ERR_COLOR_MAP;
              got = 1'b1;
              phase = PH_IDLE;
            end
            HDR_IMG_TYPE: if (d != IMAGE_TYPE_TRUECOLOR) begin
              r.kind = KIND_ERROR;
              r.error_code = ERR_IMAGE_TYPE;
              got = 1'b1;
              phase = PH_IDLE;
            end
            HDR_WIDTH_LO, HDR_HEIGHT_LO: lo_hold = d;
            HDR_WIDTH_HI: width_r = {d, lo_hold};
            HDR_HEIGHT_HI: height_r = {d, lo_hold};
            HDR_DEPTH: depth_b = d;
            HDR_DESCRIPTOR: begin
              got = 1'b1;
              if ((d & INTERLEAVE_MASK) != 8'd0) begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_INTERLEAVE;
                phase = PH_IDLE;
              end else begin
                flip = d[5];
                if (depth_b == DEPTH_24 && (d & ALPHA_BITS_MASK) == 8'd0) begin
                  alpha_m = 1'b0;
                end else if (depth_b == DEPTH_32 && (d & ALPHA_BITS_MASK) == ALPHA_BITS_8) begin
                  alpha_m = 1'b1;
                end else begin
                  r.kind = KIND_ERROR;
                  r.error_code = ERR_DEPTH;
                  phase = PH_IDLE;
                end
                if (phase != PH_IDLE) begin
                  r.kind = KIND_HEADER;
                  r.has_alpha = alpha_m;
                  r.image_width = width_r;
                  r.image_height = height_r;
                  col = '0;
                  row = '0;
                  byte_idx = '0;
                  partial = '0;
                  phase = (id_left != 0) ? PH_ID_SKIP : after_id();
                end
              end
            end
            default: ;
          endcase
          if (hdr_idx < HDR_DESCRIPTOR) hdr_idx++;
        end
        PH_ID_SKIP: begin
          id_left--;
          if (id_left == 0) phase = after_id();
        end
        PH_PIXELS: begin
          final_idx = alpha_m ? 2'd3 : 2'd2;
          if (byte_idx < final_idx) begin
            partial[8*byte_idx +: 8] = d;
            byte_idx++;
          end else begin
            r.kind = KIND_PIXEL;
            r.red = alpha_m ? partial[23:16] : d;
            r.alpha = alpha_m ? d : 8'd0;
            r.green = partial[15:8];
            r.blue = partial[7:0];
            r.pixel_x = col;
            r.pixel_y = flip ? height_r - 16'd1 - row : row;
            r.has_alpha = alpha_m;
            got = 1'b1;
            byte_idx = '0;
            partial = '0;
            if ({1'b0, col} + 17'd1 >= {1'b0, width_r}) begin
              col = '0;
              if ({1'b0, row} + 17'd1 >= {1'b0, height_r}) begin
                r.last = 1'b1;
                phase = PH_IDLE;
              end else begin
                row++;
              end
            end else begin
              col++;
            end
          end
        end
        default: ;
      endcase
      if (got) expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] exp);
      if (got !== exp) report($sformatf("%s got %0h expected %0h", name, got, exp));
    endtask

    task check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d", got.kind));
      end else begin
        exp = expected_q.pop_front();
        check_field("kind", 16'(got.kind), 16'(exp.kind));
        check_field("pixel_x", got.pixel_x, exp.pixel_x);
        check_field("pixel_y", got.pixel_y, exp.pixel_y);
        check_field("red", 16'(got.red), 16'(exp.red));
        check_field("green", 16'(got.green), 16'(exp.green));
        check_field("blue", 16'(got.blue), 16'(exp.blue));
        check_field("alpha", 16'(got.alpha), 16'(exp.alpha));
        check_field("has_alpha", 16'(got.has_alpha), 16'(exp.has_alpha));
        check_field("image_width", got.image_width, exp.image_width);
        check_field("image_height", got.image_height, exp.image_height);
        check_field("error_code", 16'(got.error_code), 16'(exp.error_code));
        check_field("last", 16'(got.last), 16'(exp.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  tga_byte_if   byte_ch ();
  tga_result_if res_ch ();

  tga_truecolor_stream_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (res_ch)
  );

  tga_scoreboard sb = new();
  logic [7:0]    file_q[$];
  int            fed_count = 0;
  bit            quiet;
  int            idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] d, input logic fs);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data  <= byte_t'{d, fs};
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    fed_count++;
    sb.note_byte(byte_t'{d, fs});
    @(negedge clk_i);
  endtask

  task automatic build_file(input logic [7:0] id_len, input logic [7:0] cmap,
                            input logic [7:0] itype, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] depth,
                            input logic [7:0] desc, input int npix);
    int bpp;
    file_q.delete();
    file_q.push_back(id_len);
    file_q.push_back(cmap);
    file_q.push_back(itype);
    repeat (9) file_q.push_back(8'($urandom_range(0, 255)));
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    file_q.push_back(depth);
    file_q.push_back(desc);
    repeat (id_len) file_q.push_back(8'($urandom_range(0, 255)));
    bpp = (depth == DEPTH_32) ? 4 : 3;
    repeat (npix * bpp) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_file(input bit fs, input int nbytes);
    int n;
    n = (nbytes < 0 || nbytes > file_q.size()) ? file_q.size() : nbytes;
    for (int i = 0; i < n; i++) send_byte(file_q[i], fs && i == 0);
  endtask

  task automatic send_noise(input int n, input bit fs);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), fs && i == 0);
  endtask

  task automatic run_directed();
    // first file after reset carries no frame_start
    build_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_24, 8'h00, 4);
    send_file(1'b0, -1);
    send_noise(2, 1'b0);
    build_file(8'd2, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd3, 16'd2, DEPTH_32, 8'h28, 6);
    send_file(1'b1, -1);
    build_file(8'd0, 8'hFF, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h00, 0);
    send_file(1'b1, 2);
    send_noise(3, 1'b0);
    build_file(8'd0, 8'd0, 8'd3, 16'd1, 16'd1, DEPTH_24, 8'h00, 0);
    send_file(1'b1, 3);
    build_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h80, 0);
    send_file(1'b1, -1);
    build_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h08, 0);
    send_file(1'b1, -1);
    build_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd16, 8'h00, 0);
    send_file(1'b1, -1);
    // empty images
    build_file(8'd1, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd3, DEPTH_24, 8'h00, 0);
    send_file(1'b1, -1);
    send_noise(3, 1'b0);
    build_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd4, 16'd0, DEPTH_32, 8'h08, 0);
    send_file(1'b1, -1);
    // widest and tallest images, cut short by a restart
    build_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'hFFFF, 16'd1, DEPTH_32, 8'h38, 3);
    send_file(1'b1, -1);
    build_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'hFFFF, DEPTH_24, 8'h30, 3);
    send_file(1'b1, -1);
    build_file(8'hFF, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h00, 1);
    send_file(1'b1, 28);
    send_file(1'b1, 7);
    send_file(1'b1, -1);
  endtask

  task automatic run_random();
    logic [7:0]  id_len;
    logic [7:0]  cmap;
    logic [7:0]  itype;
    logic [7:0]  depth;
    logic [7:0]  desc;
    logic [15:0] w;
    logic [15:0] h;
    int          nbytes;
    bit          paused;
    paused = 1'b0;
    while (fed_count < TOTAL_BYTES) begin
      quiet = ($urandom_range(0, 99) < 15);
      id_len = ($urandom_range(0, 99) < 70) ? 8'd0 :
               ($urandom_range(0, 9) != 0) ? 8'($urandom_range(1, 4)) :
               8'($urandom_range(5, 255));
      w = ($urandom_range(0, 99) < 5) ? 16'd0 :
          ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 24)) : 16'($urandom_range(1, 8));
      h = ($urandom_range(0, 99) < 4) ? 16'd0 : 16'($urandom_range(1, 4));
      cmap = 8'd0;
      itype = IMAGE_TYPE_TRUECOLOR;
      if ($urandom_range(0, 1) == 1) begin
        depth = DEPTH_32;
        desc = {2'b00, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ALPHA_BITS_8[3:0]};
      end else begin
        depth = DEPTH_24;
        desc = {2'b00, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 4'd0};
      end
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 3))
          0: cmap = 8'($urandom_range(1, 255));
          1: begin
            itype = 8'($urandom_range(0, 255));
            if (itype == IMAGE_TYPE_TRUECOLOR) itype = 8'd10;
          end
          2: desc = desc | 8'($urandom_range(1, 3) << 6);
          default: begin
            desc[3:0] = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
              0: depth = DEPTH_24;
              1: depth = DEPTH_32;
              2: depth = 8'd16;
              default: depth = 8'($urandom_range(0, 255));
            endcase
          end
        endcase
      end
      build_file(id_len, cmap, itype, w, h, depth, desc, int'(w) * int'(h));
      nbytes = ($urandom_range(0, 99) < 6) ? $urandom_range(1, file_q.size() - 1) : -1;
      send_file(1'b1, nbytes);
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 5), 1'b0);
      if ($urandom_range(0, 99) < 3) send_noise($urandom_range(1, 10), 1'b1);
      if (!paused && fed_count > TOTAL_BYTES / 2) begin
        paused = 1'b1;
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int hold_left;
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (res_ch.ready) begin
        hold_left = pick_gap();
        if (hold_left > 0) begin
          res_ch.ready <= 1'b0;
          hold_left--;
        end
      end else begin
        res_ch.ready <= 1'b1;
        hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data = '0;
    quiet = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    byte_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
